>>> design/wbps_pkg.sv
// Package: payload structs, action and register codes, cell control for the pattern search core.
`default_nettype none
package wbps_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_POS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_POS        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_LIMIT_ON   = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pattern_index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] first_byte_pos;
    logic [31:0] match_number;
    logic        beyond_end;
  } out_item_t;

  typedef enum logic {
    KIND_DATA,
    KIND_RESTART
  } item_kind_t;

  typedef struct packed {
    logic       step;
    logic       clear;
    logic       load;
    logic [7:0] load_index;
    logic [7:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/windowed_byte_pattern_search_core.sv
// Top level: row of search cells, position tracking, match count and output register.
// A data result is registered first in the cell row, then in the select/count output register.
// Throughput: one item per cycle unless the output stalls; the cell row compares all pattern
// bytes in the transfer cycle; stage two selects the flag at pattern_length, updates the count.
// Load and restart items give no result; restart clears all flags in its transfer cycle.
// Reset: flags, position and count cleared, registers at reset values; pattern bytes
// are undefined until loaded.
`default_nettype none
module windowed_byte_pattern_search_core #(
  parameter int PATTERN_DEPTH = 256,
  parameter int OFFSET_BITS   = 32
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire wbps_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output wbps_pkg::out_item_t                      out_data,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire [wbps_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  wire [wbps_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  logic [8:0]  pattern_length;
  logic [31:0] start_pos;
  logic [31:0] end_pos;
  logic        end_limit_on;

  logic [PATTERN_DEPTH-1:0] flags;
  logic [OFFSET_BITS-1:0]   position;
  logic [31:0]              match_total;

  logic                 s2_valid;
  wbps_pkg::item_kind_t s2_kind;
  logic                 s2_beyond;
  logic [31:0]          s2_offset;

  logic                 in_fire;
  logic                 s2_move;
  logic                 is_data;
  logic                 is_restart;
  logic                 beyond;
  logic [IDX_W-1:0]     len_m1;
  logic [OFFSET_BITS-1:0] end_cut;
  logic [OFFSET_BITS-1:0] first_pos;
  logic                 hit;
  logic [31:0]          total_next;
  wbps_pkg::cell_ctl_t  ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 9'd1;
      start_pos      <= '0;
      end_pos        <= '0;
      end_limit_on   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[8:0];
        wbps_pkg::REG_START_POS:      start_pos      <= cfg_data;
        wbps_pkg::REG_END_POS:        end_pos        <= cfg_data;
        wbps_pkg::REG_END_LIMIT_ON:   end_limit_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == 9'd0) begin
      len_m1 = '0;
    end else if (32'(pattern_length) > 32'(PATTERN_DEPTH)) begin
      len_m1 = IDX_W'(PATTERN_DEPTH - 1);
    end else begin
      len_m1 = IDX_W'(pattern_length - 9'd1);
    end
  end

  assign end_cut    = OFFSET_BITS'(end_pos);
  assign in_fire    = in_valid && in_ready;
  assign is_data    = (in_data.action == wbps_pkg::ACT_DATA);
  assign is_restart = (in_data.action == wbps_pkg::ACT_RESTART);
  assign beyond     = end_limit_on && (position > end_cut);
  assign first_pos  = position - OFFSET_BITS'(len_m1);

  assign s2_move  = s2_valid && ((s2_kind == wbps_pkg::KIND_RESTART) || !out_valid || out_ready);
  assign in_ready = !s2_valid || s2_move;

  always_comb begin
    ctl.step       = in_fire && is_data && !beyond;
    ctl.clear      = in_fire && is_restart;
    ctl.load       = in_fire && (in_data.action == wbps_pkg::ACT_LOAD);
    ctl.load_index = in_data.pattern_index;
    ctl.value      = in_data.value;
  end

  for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = flags[i-1];
    end
    wbps_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev_flag(prev),
      .flag     (flags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (ctl.clear) begin
      position <= OFFSET_BITS'(start_pos);
    end else if (ctl.step) begin
      position <= position + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_ready) begin
      s2_valid <= in_fire && (is_data || is_restart);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s2_kind   <= is_restart ? wbps_pkg::KIND_RESTART : wbps_pkg::KIND_DATA;
      s2_beyond <= beyond;
      s2_offset <= 32'(first_pos);
    end
  end

  assign hit = flags[len_m1] && !s2_beyond;

  always_comb begin
    total_next = match_total;
    if (hit && (match_total != 32'hFFFF_FFFF)) begin
      total_next = match_total + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total <= '0;
    end else if (s2_move) begin
      if (s2_kind == wbps_pkg::KIND_RESTART) begin
        match_total <= '0;
      end else begin
        match_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move && (s2_kind == wbps_pkg::KIND_DATA)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && (s2_kind == wbps_pkg::KIND_DATA)) begin
      out_data.found          <= hit;
      out_data.first_byte_pos <= hit ? s2_offset : 32'd0;
      out_data.match_number   <= total_next;
      out_data.beyond_end     <= s2_beyond;
    end
  end

  a_found_not_beyond: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.found && out_data.beyond_end))
    else $error("found and beyond_end both set");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.first_byte_pos == 32'd0))
    else $error("first_byte_pos nonzero without a match");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s2_move && (s2_kind == wbps_pkg::KIND_DATA)) |=> (match_total >= $past(match_total)))
    else $error("match count decreased on a data byte");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_move) |-> !in_ready)
    else $error("input taken while second stage is stalled");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_restart) |=> (flags == '0))
    else $error("flags not cleared after restart transfer");

endmodule
`default_nettype wire

>>> design/wbps_cell.sv
// One search cell: holds a pattern byte and its partial-match flag.
`default_nettype none
module wbps_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire wbps_pkg::cell_ctl_t ctl,
  input  wire                      prev_flag,
  output logic                     flag
);

  logic [7:0] pattern;

  always_ff @(posedge clk) begin
    if (ctl.load && (32'(ctl.load_index) == 32'(CELL_INDEX))) begin
      pattern <= ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.clear) begin
      flag <= 1'b0;
    end else if (ctl.step) begin
      flag <= prev_flag && (pattern == ctl.value);
    end
  end

endmodule
`default_nettype wire

>>> sim/pattern_search_checker.sv
// Checker: watches the three channels, tracks the search state and compares each result.
module pattern_search_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire                             in_ready,
  input  wbps_pkg::in_item_t              in_data,
  input  wire                             out_valid,
  input  wire                             out_ready,
  input  wbps_pkg::out_item_t             out_data,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [wbps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              awaiting,
  output int                              reports,
  output int                              hits,
  output int                              stopped
);

  localparam int DEPTH = 256;

  logic [7:0]       pat_bytes [DEPTH];
  logic [DEPTH-1:0] prefix_hits;
  logic [31:0]      stream_pos;
  logic [31:0]      hit_total;
  logic [8:0]       len_reg;
  logic [31:0]      start_reg;
  logic [31:0]      end_reg;
  logic             limit_reg;

  wbps_pkg::out_item_t byte_reports [$];
  wbps_pkg::out_item_t due;
  int        fail_count = 0;
  int        seen = 0;
  int        hit_seen = 0;
  int        beyond_seen = 0;

  // One data byte through the shift-and search; within the end limit it updates flags, position and count.
  function automatic wbps_pkg::out_item_t scan_byte(input logic [7:0] b);
    wbps_pkg::out_item_t r;
    logic [DEPTH-1:0]    nxt;
    int unsigned         span;
    r = '0;
    if (limit_reg && stream_pos > end_reg) begin
      r.match_number = hit_total;
      r.beyond_end   = 1'b1;
    end else begin
      nxt[0] = pat_bytes[0] == b;
      for (int i = 1; i < DEPTH; i++) begin
        nxt[i] = prefix_hits[i-1] && pat_bytes[i] == b;
      end
      prefix_hits = nxt;
      span = (len_reg == 0) ? 1 : ((len_reg > DEPTH) ? DEPTH : len_reg);
      if (prefix_hits[span-1]) begin
        if (hit_total != 32'hFFFF_FFFF) begin
          hit_total = hit_total + 1;
        end
        r.found          = 1'b1;
        r.first_byte_pos = stream_pos - 32'(span - 1);
      end
      r.match_number = hit_total;
      stream_pos     = stream_pos + 1;
    end
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        pat_bytes[i] = 8'h00;
      end
      prefix_hits = '0;
      stream_pos  = '0;
      hit_total   = '0;
      len_reg     = 9'd1;
      start_reg   = '0;
      end_reg     = '0;
      limit_reg   = 1'b0;
      byte_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wbps_pkg::REG_PATTERN_LENGTH: len_reg   = cfg_data[8:0];
          wbps_pkg::REG_START_POS:      start_reg = cfg_data;
          wbps_pkg::REG_END_POS:        end_reg   = cfg_data;
          wbps_pkg::REG_END_LIMIT_ON:   limit_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (byte_reports.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          due = byte_reports.pop_front();
          seen++;
          if (due.found) hit_seen++;
          if (due.beyond_end) beyond_seen++;
          report_field("found", 32'(due.found), 32'(out_data.found));
          report_field("first_byte_pos", due.first_byte_pos, out_data.first_byte_pos);
          report_field("match_number", due.match_number, out_data.match_number);
          report_field("beyond_end", 32'(due.beyond_end), 32'(out_data.beyond_end));
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.action)
          wbps_pkg::ACT_LOAD: pat_bytes[in_data.pattern_index] = in_data.value;
          wbps_pkg::ACT_RESTART: begin
            prefix_hits = '0;
            stream_pos  = start_reg;
            hit_total   = '0;
          end
          wbps_pkg::ACT_DATA: byte_reports.push_back(scan_byte(in_data.value));
          default: ;
        endcase
      end
    end
    mismatches <= fail_count;
    awaiting   <= byte_reports.size();
    reports    <= seen;
    hits       <= hit_seen;
    stopped    <= beyond_seen;
  end

endmodule

>>> sim/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the pattern search core.
module testbench;

  localparam int         CYCLE_LIMIT = 500000;
  localparam int         PHASES      = 10;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  wbps_pkg::in_item_t               in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  wbps_pkg::out_item_t              out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches, awaiting, reports, hits, stopped;
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int cycles = 0;
  int sent = 0;

  logic [7:0]  pat_img [256];
  logic [7:0]  feed [$];
  logic [7:0]  alpha [2];
  int unsigned span;
  int          budget, n, pick, at;
  logic [31:0] len_w, start_w, end_w;
  logic        limit_w;

  windowed_byte_pattern_search_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pattern_search_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting),
    .reports    (reports),
    .hits       (hits),
    .stopped    (stopped)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, awaiting);
      $display("** windowed_byte_pattern_search_core: FAILED **");
      $finish;
    end
  end

  // Random result side backpressure in bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic [7:0] val);
    cfg_valid <= 1'b0;
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {act, idx, val};
    do @(posedge clk); while (!in_ready);
    if (act != ACT_NONE) sent++;
  endtask

  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drop valids, wait for every outstanding result, then let the pipe empty.
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    gap_odds = 6;
    stall_odds <= 6;

    // fill the whole store so no compare ever sees an unwritten byte
    for (int i = 0; i < 256; i++) begin
      pat_img[i] = 8'($urandom);
      push_item(wbps_pkg::ACT_LOAD, 8'(i), pat_img[i]);
    end

    // directed: two-byte pattern across the position wrap, then the end limit
    settle();
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, 32'd2);
    write_reg(wbps_pkg::REG_START_POS, 32'hFFFF_FFFE);
    write_reg(wbps_pkg::REG_END_POS, 32'd0);
    write_reg(wbps_pkg::REG_END_LIMIT_ON, 32'd0);
    pat_img[0]   = 8'h00;
    pat_img[1]   = 8'hFF;
    pat_img[255] = 8'hFF;
    push_item(wbps_pkg::ACT_LOAD, 8'd0, 8'h00);
    push_item(wbps_pkg::ACT_LOAD, 8'd1, 8'hFF);
    push_item(wbps_pkg::ACT_LOAD, 8'hFF, 8'hFF);
    push_item(wbps_pkg::ACT_RESTART, 8'd0, 8'd0);
    for (int k = 0; k < 6; k++) push_item(wbps_pkg::ACT_DATA, 8'hFF, k[0] ? 8'hFF : 8'h00);
    push_item(ACT_NONE, 8'hFF, 8'hFF);
    settle();
    write_reg(wbps_pkg::REG_START_POS, 32'd0);
    write_reg(wbps_pkg::REG_END_POS, 32'd3);
    write_reg(wbps_pkg::REG_END_LIMIT_ON, 32'd1);
    push_item(wbps_pkg::ACT_RESTART, 8'hFF, 8'hFF);
    for (int k = 0; k < 6; k++) push_item(wbps_pkg::ACT_DATA, 8'd0, k[0] ? 8'hFF : 8'h00);
    push_item(wbps_pkg::ACT_RESTART, 8'd0, 8'd0);
    push_item(wbps_pkg::ACT_DATA, 8'd0, 8'h00);
    push_item(wbps_pkg::ACT_DATA, 8'd0, 8'hFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph >= PHASES - 2) begin
        gap_odds = 0;
        stall_odds <= 0;
      end else begin
        pick = $urandom_range(0, 2);
        gap_odds = (pick == 0) ? 0 : ((pick == 1) ? 2 : 7);
        pick = $urandom_range(0, 2);
        stall_odds <= (pick == 0) ? 0 : ((pick == 1) ? 2 : 7);
      end

      len_w = $urandom;
      case (ph)
        0: len_w[8:0] = 9'h100;
        1: len_w[8:0] = 9'h000;
        2: len_w[8:0] = 9'h1FF;
        default: len_w[8:0] = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(9, 40))
                                                          : 9'($urandom_range(1, 8));
      endcase
      span = (len_w[8:0] == 0) ? 1 : ((len_w[8:0] > 256) ? 256 : len_w[8:0]);

      case ($urandom_range(0, 3))
        0: start_w = 32'd0;
        1: start_w = 32'hFFFF_FFFF - $urandom_range(0, 40);
        2: start_w = $urandom;
        default: start_w = 32'hFFFF_FFFF;
      endcase
      if (ph == 1 || ph == 5) start_w = 32'd0;
      if (ph == 3) start_w = 32'hFFFF_FFFF;
      limit_w = 1'($urandom_range(0, 1));
      end_w   = start_w + $urandom_range(0, 150);
      if (ph == 4) begin
        limit_w = 1'b1;
        end_w   = 32'hFFFF_FFFF;
      end
      if (ph == 5) begin
        limit_w = 1'b1;
        end_w   = 32'd0;
      end

      write_reg(wbps_pkg::REG_PATTERN_LENGTH, len_w);
      write_reg(wbps_pkg::REG_START_POS, start_w);
      write_reg(wbps_pkg::REG_END_POS, end_w);
      write_reg(wbps_pkg::REG_END_LIMIT_ON, {31'($urandom), limit_w});

      if (ph <= 5 || $urandom_range(0, 3) != 0) begin
        push_item(wbps_pkg::ACT_RESTART, 8'($urandom), 8'($urandom));
      end
      if (ph < 3 || $urandom_range(0, 3) != 0) begin
        // small alphabet so that overlapping occurrences are common
        alpha[0] = 8'($urandom);
        alpha[1] = $urandom_range(0, 1) ? (alpha[0] ^ 8'h01) : 8'($urandom);
        for (int i = 0; i < span; i++) begin
          pat_img[i] = ($urandom_range(0, 5) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 1)];
          push_item(wbps_pkg::ACT_LOAD, 8'(i), pat_img[i]);
        end
      end

      feed.delete();
      budget = span + 20;
      n = 0;
      while (n < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          at = $urandom_range(0, 255);
          pat_img[at] = 8'($urandom);
          push_item(wbps_pkg::ACT_LOAD, 8'(at), pat_img[at]);
          n++;
        end else if (pick < 5) begin
          push_item(wbps_pkg::ACT_RESTART, 8'($urandom), 8'($urandom));
          n++;
        end else if (pick < 6) begin
          push_item(ACT_NONE, 8'($urandom), 8'($urandom));
        end else begin
          if (feed.size() == 0) begin
            pick = $urandom_range(0, 9);
            at   = $urandom_range(0, span - 1);
            if (pick < 5) begin
              for (int i = 0; i < span; i++) feed.push_back(pat_img[i]);
            end else if (pick < 7) begin
              for (int i = 0; i < at; i++) feed.push_back(pat_img[i]);
              feed.push_back(8'($urandom));
            end else if (pick < 8) begin
              for (int i = 0; i < span; i++) begin
                feed.push_back((i == at) ? pat_img[i] ^ (8'h01 << $urandom_range(0, 7))
                                         : pat_img[i]);
              end
            end else begin
              repeat ($urandom_range(1, 6)) begin
                feed.push_back($urandom_range(0, 1) ? pat_img[$urandom_range(0, span - 1)]
                                                    : 8'($urandom));
              end
            end
          end
          push_item(wbps_pkg::ACT_DATA, 8'($urandom), feed.pop_front());
          n++;
        end
      end
    end

    settle();
    $display("%0d items over %0d register settings; %0d byte results checked", sent,
             PHASES + 2, reports);
    $display("%0d occurrences found, %0d bytes past the end limit", hits, stopped);
    if (mismatches == 0 && awaiting == 0) begin
      $display("** windowed_byte_pattern_search_core: PASSED **");
    end else begin
      $display("** windowed_byte_pattern_search_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> windowed_byte_pattern_search_core.f
design/wbps_pkg.sv
design/wbps_cell.sv
design/windowed_byte_pattern_search_core.sv
sim/pattern_search_checker.sv
sim/testbench.sv
